>>> hdl/lsm_pkg.sv
// Shared types and constants for the line substring matcher.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package lsm_pkg;

  // Default sizes of the pattern store and of the kept part of a line
  localparam int LSM_PATTERN_MAX = 127;
  localparam int LSM_LINE_KEEP   = 511;

  // Fixed field widths
  localparam int BYTE_W   = 8;
  localparam int PIDX_W   = 7;
  localparam int PLEN_W   = 7;
  localparam int KEPT_W   = 9;
  localparam int LINE_W   = 32;
  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 32;

  // Item actions
  typedef enum logic [1:0] {
    ACT_DATA  = 2'd0,
    ACT_PATW  = 2'd1,
    ACT_START = 2'd2
  } action_t;

  // Register index (paddr bit 2)
  localparam logic REG_PATLEN = 1'b0;

  // Line terminators
  localparam logic [BYTE_W-1:0] CHAR_NL  = 8'h0A;
  localparam logic [BYTE_W-1:0] CHAR_NUL = 8'h00;

  // Control of the window and pattern store
  typedef struct packed {
    logic              shift_en;
    logic [BYTE_W-1:0] shift_byte;
    logic              pat_we;
    logic [PIDX_W-1:0] pat_idx;
    logic [BYTE_W-1:0] pat_byte;
  } win_ctl_t;

endpackage

`default_nettype wire

>>> hdl/line_substring_matcher_top.sv
// Output: the result of a line-end transfer is registered on out_*.
// Throughput: one input item per cycle; the input stalls only when both the
// output register and the skid register hold results not yet taken.
// The window compare for a kept byte is resolved in the cycle after it.
// Reset: synchronous, active low; counters, flags and pattern length reset at
// once, no clearing pass; the pattern store holds nothing until written.
`timescale 1ns / 1ps
`default_nettype none

module line_substring_matcher_top
  import lsm_pkg::*;
#(
  parameter int PATTERN_MAX = LSM_PATTERN_MAX,
  parameter int LINE_KEEP   = LSM_LINE_KEEP
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // input channel
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [1:0]        in_action,
  input  wire logic [BYTE_W-1:0] in_byte_value,
  input  wire logic [PIDX_W-1:0] in_pattern_index,
  // result channel
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [LINE_W-1:0]      out_line_number,
  output logic                   out_line_matched,
  output logic                   out_any_match,
  output logic [KEPT_W-1:0]      out_kept_length,
  // configuration port
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0]      prdata,
  output logic                   pready
);

  localparam int LEN_W = $clog2(PATTERN_MAX + 1);
  localparam int CNT_W = $clog2(LINE_KEEP + 1);

  typedef struct packed {
    logic [LINE_W-1:0] line_number;
    logic              line_matched;
    logic              any_match;
    logic [KEPT_W-1:0] kept_length;
  } res_t;

  // configuration
  logic [PLEN_W-1:0] len_r;
  logic [7:0]        len_wide;
  logic [LEN_W-1:0]  len_used;
  logic              cfg_wr;

  // line state
  logic [CNT_W-1:0]  kept_r, kept_nxt;
  logic [LINE_W-1:0] cnt_r, cnt_nxt;
  logic              line_hit_r, line_hit_nxt;
  logic              found_r, found_nxt;
  logic              chk_r, chk_nxt;

  // item decode
  logic              in_fire;
  logic              is_data;
  logic              is_eol;
  logic              keep;
  logic              mt_hit;
  logic              hit_acc;
  logic              matched;
  logic              push;
  logic              pop;
  res_t              res_new;
  win_ctl_t          wctl;

  // output register and skid register
  res_t              out_r, out_nxt;
  res_t              skid_r, skid_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              skid_valid_r, skid_valid_nxt;

  // ---------------------------------------------------------------------
  // Configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= PLEN_W'(1);
    end else if (cfg_wr && (paddr[2] == REG_PATLEN)) begin
      len_r <= pwdata[PLEN_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_PATLEN) ? CFG_DW'(len_r) : '0;

  // Clamp the length to the store size
  assign len_wide = ({1'b0, len_r} > 8'(PATTERN_MAX)) ? 8'(PATTERN_MAX) : {1'b0, len_r};
  assign len_used = LEN_W'(len_wide);

  // ---------------------------------------------------------------------
  // Window and pattern compare
  assign in_ready = !skid_valid_r;
  assign in_fire  = in_valid & in_ready;
  assign is_data  = (in_action == ACT_DATA);
  assign is_eol   = is_data && ((in_byte_value == CHAR_NL) || (in_byte_value == CHAR_NUL));
  assign keep     = is_data && !is_eol && (32'(kept_r) < 32'(LINE_KEEP));

  always_comb begin
    wctl.shift_en   = in_fire & keep;
    wctl.shift_byte = in_byte_value;
    wctl.pat_we     = in_fire & (in_action == ACT_PATW);
    wctl.pat_idx    = in_pattern_index;
    wctl.pat_byte   = in_byte_value;
  end

  lsm_matcher #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_matcher (
    .clk      (clk),
    .ctl      (wctl),
    .len_used (len_used),
    .hit      (mt_hit)
  );

  // Fold in the compare of the byte kept in the previous cycle
  assign hit_acc = line_hit_r | (chk_r & mt_hit);
  assign matched = hit_acc | (len_used == '0);

  always_comb begin
    res_new.line_number  = cnt_r;
    res_new.line_matched = matched;
    res_new.any_match    = found_r | matched;
    res_new.kept_length  = KEPT_W'(kept_r);
  end

  // ---------------------------------------------------------------------
  // Line state update
  always_comb begin
    kept_nxt     = kept_r;
    cnt_nxt      = cnt_r;
    line_hit_nxt = hit_acc;
    found_nxt    = found_r;
    chk_nxt      = 1'b0;
    push         = 1'b0;
    if (in_fire) begin
      unique case (in_action)
        ACT_DATA: begin
          if (is_eol) begin
            push         = 1'b1;
            found_nxt    = found_r | matched;
            cnt_nxt      = (cnt_r == '1) ? cnt_r : cnt_r + LINE_W'(1);
            kept_nxt     = '0;
            line_hit_nxt = 1'b0;
          end else if (keep) begin
            kept_nxt = kept_r + CNT_W'(1);
            chk_nxt  = (len_used != '0) && ((32'(kept_r) + 32'd1) >= 32'(len_used));
          end
        end
        ACT_START: begin
          cnt_nxt      = LINE_W'(1);
          found_nxt    = 1'b0;
          kept_nxt     = '0;
          line_hit_nxt = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kept_r     <= '0;
      cnt_r      <= LINE_W'(1);
      line_hit_r <= 1'b0;
      found_r    <= 1'b0;
      chk_r      <= 1'b0;
    end else begin
      kept_r     <= kept_nxt;
      cnt_r      <= cnt_nxt;
      line_hit_r <= line_hit_nxt;
      found_r    <= found_nxt;
      chk_r      <= chk_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Output register with skid stage
  assign pop = out_valid_r & out_ready;

  always_comb begin
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (!out_valid_r || pop) begin
      if (skid_valid_r) begin
        out_nxt        = skid_r;
        out_valid_nxt  = 1'b1;
        skid_nxt       = res_new;
        skid_valid_nxt = push;
      end else begin
        out_nxt       = res_new;
        out_valid_nxt = push;
      end
    end else if (push) begin
      skid_nxt       = res_new;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // Hold the payload registers; no reset needed
  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_line_number  = out_r.line_number;
  assign out_line_matched = out_r.line_matched;
  assign out_any_match    = out_r.any_match;
  assign out_kept_length  = out_r.kept_length;

  // ---------------------------------------------------------------------
  // Assertions
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register holds a result while the output register is empty");

  a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != '0)
    else $error("line counter reached zero");

  a_kept_limit: assert property (@(posedge clk) disable iff (!rst_n)
    32'(kept_r) <= 32'(LINE_KEEP))
    else $error("kept count ran past the keep limit");

  a_found_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (push && matched) |=> found_r)
    else $error("any-match flag not set after a matching line");

endmodule

`default_nettype wire

>>> hdl/lsm_matcher.sv
// Window of recent kept bytes, pattern store and parallel window compare.
// Depends on lsm_pkg for the control struct and field widths.
`timescale 1ns / 1ps
`default_nettype none

module lsm_matcher
  import lsm_pkg::*;
#(
  parameter int PATTERN_MAX = LSM_PATTERN_MAX,
  localparam int LEN_W = $clog2(PATTERN_MAX + 1)
) (
  input  wire logic             clk,
  input  wire win_ctl_t         ctl,
  input  wire logic [LEN_W-1:0] len_used,
  output logic                  hit
);

  logic [BYTE_W-1:0] win_r [PATTERN_MAX];
  logic [BYTE_W-1:0] pat_r [PATTERN_MAX];

  logic [BYTE_W*PATTERN_MAX-1:0] rev_flat;
  logic [BYTE_W*PATTERN_MAX-1:0] aligned_flat;
  logic [LEN_W-1:0]              shamt;
  logic [PATTERN_MAX-1:0]        eq;

  // Shift the newest kept byte in at entry 0
  always_ff @(posedge clk) begin
    if (ctl.shift_en) begin
      win_r[0] <= ctl.shift_byte;
    end
  end

  for (genvar i = 1; i < PATTERN_MAX; i++) begin : g_shift
    always_ff @(posedge clk) begin
      if (ctl.shift_en) begin
        win_r[i] <= win_r[i-1];
      end
    end
  end

  // Pattern store: one write enable per entry, writes past the end drop out
  for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_pat
    always_ff @(posedge clk) begin
      if (ctl.pat_we && ({1'b0, ctl.pat_idx} == 8'(k))) begin
        pat_r[k] <= ctl.pat_byte;
      end
    end
  end

  // Oldest byte first, then drop the bytes older than the pattern length
  for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_rev
    assign rev_flat[BYTE_W*k +: BYTE_W] = win_r[PATTERN_MAX-1-k];
  end

  assign shamt        = LEN_W'(PATTERN_MAX) - len_used;
  assign aligned_flat = rev_flat >> {shamt, 3'b000};

  // Compare each pattern position; positions past the length always agree
  for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_cmp
    assign eq[j] = (aligned_flat[BYTE_W*j +: BYTE_W] == pat_r[j]) ||
                   (LEN_W'(j) >= len_used);
  end

  assign hit = &eq;

endmodule

`default_nettype wire

>>> tb/line_substring_matcher_top_tb.sv
// Self-checking bench for the line substring matcher: random and directed byte
// streams, pattern loads and length changes, checked against an in-bench predictor.
// Depends on lsm_pkg and line_substring_matcher_top.
`timescale 1ns / 1ps

module line_substring_matcher_top_tb;
  import lsm_pkg::*;

  // Spare action code that the block must ignore
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  // Byte address of the pattern length register
  localparam logic [CFG_AW-1:0] ADDR_PATLEN = {REG_PATLEN, 2'b00};

  typedef struct {
    logic [1:0]        act;
    logic [BYTE_W-1:0] value;
    logic [PIDX_W-1:0] idx;
  } stim_item_t;

  typedef struct {
    logic [LINE_W-1:0] line_number;
    logic              line_matched;
    logic              any_match;
    logic [KEPT_W-1:0] kept_length;
  } line_report_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [1:0]        in_action = ACT_DATA;
  logic [BYTE_W-1:0] in_byte_value = '0;
  logic [PIDX_W-1:0] in_pattern_index = '0;

  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [LINE_W-1:0] out_line_number;
  logic              out_line_matched;
  logic              out_any_match;
  logic [KEPT_W-1:0] out_kept_length;

  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [CFG_DW-1:0] pwdata = '0;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  line_substring_matcher_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_byte_value    (in_byte_value),
    .in_pattern_index (in_pattern_index),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_line_number  (out_line_number),
    .out_line_matched (out_line_matched),
    .out_any_match    (out_any_match),
    .out_kept_length  (out_kept_length),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Stimulus side: items waiting to be sent and the pattern as the generator intends it
  stim_item_t   pending_items[$];
  stim_item_t   next_item;
  logic [7:0]   gen_pattern[LSM_PATTERN_MAX];
  bit           gen_written[LSM_PATTERN_MAX];
  int           gen_len = 1;
  int           stim_count = 0;
  int           send_idle_pct = 0;
  int           recv_idle_pct = 0;
  bit           sender_hold = 1'b0;
  logic         in_fired = 1'b0;

  // Predicted matcher state
  logic [7:0]        exp_pattern[LSM_PATTERN_MAX];
  logic [7:0]        exp_window[LSM_PATTERN_MAX];
  int                exp_kept = 0;
  bit                exp_hit = 1'b0;
  logic [LINE_W-1:0] exp_line_no = 1;
  bit                exp_found = 1'b0;
  int                exp_pat_len = 1;
  line_report_t      line_reports[$];

  int failures = 0;
  int n_transfers = 0;
  int n_reports = 0;
  int n_matched = 0;
  int n_lengths = 0;
  int max_kept = 0;

  initial begin
    for (int i = 0; i < LSM_PATTERN_MAX; i++) begin
      exp_pattern[i] = '0;
      exp_window[i] = '0;
      gen_pattern[i] = '0;
      gen_written[i] = 1'b0;
    end
  end

  // Advance the predicted state by one accepted transfer
  task automatic track_matcher_transfer(input logic [1:0] act, input logic [7:0] b,
                                        input logic [PIDX_W-1:0] idx);
    int unsigned  used;
    bit           window_ok;
    line_report_t rep;
    used = (exp_pat_len > LSM_PATTERN_MAX) ? LSM_PATTERN_MAX : exp_pat_len;
    case (act)
      ACT_PATW: begin
        if (idx < LSM_PATTERN_MAX) exp_pattern[idx] = b;
      end
      ACT_START: begin
        exp_line_no = 1;
        exp_found = 1'b0;
        exp_kept = 0;
        exp_hit = 1'b0;
      end
      ACT_DATA: begin
        if (b == CHAR_NL || b == CHAR_NUL) begin
          // Line end: report and clear the per-line state
          rep.line_matched = exp_hit || used == 0;
          if (rep.line_matched) exp_found = 1'b1;
          rep.line_number = exp_line_no;
          rep.any_match = exp_found;
          rep.kept_length = KEPT_W'(exp_kept);
          line_reports.push_back(rep);
          if (exp_line_no != '1) exp_line_no++;
          exp_kept = 0;
          exp_hit = 1'b0;
        end else if (exp_kept < LSM_LINE_KEEP) begin
          // Kept byte: shift the window and compare the newest bytes with the pattern
          for (int k = LSM_PATTERN_MAX - 1; k > 0; k--) exp_window[k] = exp_window[k-1];
          exp_window[0] = b;
          exp_kept++;
          if (used != 0 && exp_kept >= used) begin
            window_ok = 1'b1;
            for (int j = 0; j < used; j++)
              if (exp_pattern[j] != exp_window[used-1-j]) window_ok = 1'b0;
            if (window_ok) exp_hit = 1'b1;
          end
        end
      end
      default: ;
    endcase
  endtask

  // Check the result transfer, then predict from the input transfer
  always @(posedge clk) begin
    line_report_t want;
    if (!rst_n) begin
      in_fired <= 1'b0;
    end else begin
      in_fired <= in_valid && in_ready;
      if (out_valid === 1'b1 && out_ready) begin
        n_reports++;
        if (out_line_matched) n_matched++;
        if (out_kept_length > max_kept) max_kept = out_kept_length;
        if (line_reports.size() == 0) begin
          $error("line report with none expected: line_number %0d", out_line_number);
          failures++;
        end else begin
          want = line_reports.pop_front();
          if (out_line_number !== want.line_number) begin
            $error("line_number: expected %0d, got %0d", want.line_number, out_line_number);
            failures++;
          end
          if (out_line_matched !== want.line_matched) begin
            $error("line_matched: expected %0d, got %0d", want.line_matched,
                   out_line_matched);
            failures++;
          end
          if (out_any_match !== want.any_match) begin
            $error("any_match: expected %0d, got %0d", want.any_match, out_any_match);
            failures++;
          end
          if (out_kept_length !== want.kept_length) begin
            $error("kept_length: expected %0d, got %0d", want.kept_length,
                   out_kept_length);
            failures++;
          end
        end
      end
      if (in_valid && in_ready) begin
        n_transfers++;
        track_matcher_transfer(in_action, in_byte_value, in_pattern_index);
      end
    end
  end

  // Pick the idling pattern from the number of transfers so far
  always @(posedge clk) begin
    if (n_transfers < 383) begin
      send_idle_pct <= 8;
      recv_idle_pct <= 58;
    end else if (n_transfers < 766) begin
      send_idle_pct <= 58;
      recv_idle_pct <= 8;
    end else begin
      send_idle_pct <= 0;
      recv_idle_pct <= 0;
    end
  end

  // Sender: hold the item until its transfer, then take the next one or idle
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_fired)) begin
      if (pending_items.size() != 0 && !sender_hold &&
          $urandom_range(99) >= send_idle_pct) begin
        next_item = pending_items.pop_front();
        in_valid <= 1'b1;
        in_action <= next_item.act;
        in_byte_value <= next_item.value;
        in_pattern_index <= next_item.idx;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: stall at random
  always @(negedge clk) begin
    out_ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic push_item(input logic [1:0] act, input logic [7:0] value,
                           input logic [PIDX_W-1:0] idx);
    stim_item_t it;
    it.act = act;
    it.value = value;
    it.idx = idx;
    pending_items.push_back(it);
    if (act == ACT_PATW && idx < LSM_PATTERN_MAX) begin
      gen_pattern[idx] = value;
      gen_written[idx] = 1'b1;
    end
    if (!(act == ACT_UNUSED || (act == ACT_PATW && idx >= LSM_PATTERN_MAX))) stim_count++;
  endtask

  // Text byte: mostly a tiny alphabet so partial matches are common, never a line end
  function automatic logic [7:0] pick_text_byte();
    logic [7:0] b;
    if ($urandom_range(3) != 0) return 8'h61 + 8'($urandom_range(2));
    b = 8'($urandom_range(255, 1));
    if (b == CHAR_NL) b = 8'h0B;
    return b;
  endfunction

  // One line with an optional copy of the pattern at byte 'where', then a terminator
  task automatic push_line(input int len, input int where, input bit near_miss);
    logic [7:0] b;
    logic [7:0] alt;
    for (int i = 0; i < len; i++) begin
      if (where >= 0 && i >= where && i < where + gen_len) begin
        b = gen_pattern[i - where];
        if (near_miss && i == where + gen_len - 1) begin
          alt = pick_text_byte();
          b = (alt != b) ? alt : ((b == 8'h61) ? 8'h62 : 8'h61);
        end
      end else begin
        b = pick_text_byte();
      end
      push_item(ACT_DATA, b, PIDX_W'($urandom));
    end
    push_item(ACT_DATA, $urandom_range(1) ? CHAR_NL : CHAR_NUL, PIDX_W'($urandom));
  endtask

  // Wait until nothing is queued, in flight or expected, then let the block settle
  task automatic drain();
    do @(posedge clk);
    while (pending_items.size() != 0 || in_valid || line_reports.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  // Write the pattern length while idle, then read it back
  task automatic load_pattern_length(input int len);
    drain();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_PATLEN;
    pwdata <= CFG_DW'(len);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    exp_pat_len = len;
    gen_len = len;
    n_lengths++;
    @(negedge clk);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[PLEN_W-1:0] !== PLEN_W'(len)) begin
      $error("pattern_length: expected %0d, got %0d", len, prdata[PLEN_W-1:0]);
      failures++;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin : stimulus
    int len;
    int line_len;
    int where;
    int sel;
    int nlines;
    int phase;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: operations, ignored items, empty lines and both terminators
    push_item(ACT_PATW, 8'h61, 7'd0);
    push_item(ACT_PATW, 8'hFF, 7'd126);
    push_item(ACT_PATW, 8'h5A, 7'd127);
    push_item(ACT_UNUSED, 8'hFF, 7'd127);
    push_item(ACT_DATA, 8'hFF, 7'd0);
    push_item(ACT_DATA, 8'h61, 7'd0);
    push_item(ACT_DATA, CHAR_NL, 7'd0);
    push_item(ACT_DATA, CHAR_NL, 7'd0);
    push_item(ACT_DATA, 8'h80, 7'd127);
    push_item(ACT_DATA, CHAR_NUL, 7'd0);
    push_item(ACT_START, 8'h00, 7'd0);
    push_item(ACT_DATA, 8'h62, 7'd0);
    push_item(ACT_DATA, CHAR_NUL, 7'd0);
    // Empty pattern matches every line, the empty one too
    load_pattern_length(0);
    push_item(ACT_DATA, CHAR_NL, 7'd0);
    push_item(ACT_DATA, 8'h7A, 7'd0);
    push_item(ACT_DATA, CHAR_NL, 7'd0);
    // A pattern holding a newline can never match
    push_item(ACT_PATW, CHAR_NL, 7'd0);
    load_pattern_length(1);
    push_item(ACT_DATA, 8'h71, 7'd0);
    push_item(ACT_DATA, CHAR_NL, 7'd0);
    push_item(ACT_DATA, CHAR_NUL, 7'd0);

    // Random phases, each with its own pattern length
    stim_count = 0;
    phase = 0;
    while (stim_count < 1150) begin
      case (phase)
        0: len = LSM_PATTERN_MAX;
        1: len = 1;
        2: len = 0;
        3: len = 2;
        default: begin
          sel = $urandom_range(99);
          if (sel < 5) len = 0;
          else if (sel < 30) len = $urandom_range(LSM_PATTERN_MAX, 9);
          else len = $urandom_range(8, 1);
        end
      endcase
      // Every pattern byte in use must be written before the length covers it
      for (int i = 0; i < len; i++) begin
        if (phase == 3) push_item(ACT_PATW, (i == 0) ? 8'h78 : 8'h79, PIDX_W'(i));
        else if (!gen_written[i] || $urandom_range(1))
          push_item(ACT_PATW, pick_text_byte(), PIDX_W'(i));
      end
      load_pattern_length(len);
      if (phase == 3) begin
        // Pattern straddles the keep limit: its last byte is dropped, so no match
        push_line(LSM_LINE_KEEP + 19, LSM_LINE_KEEP - 1, 1'b0);
      end
      nlines = (len > 40) ? 2 : 12;
      for (int k = 0; k < nlines; k++) begin
        if (phase == 1 && k == nlines / 2) begin
          // Hold the sender with items queued until every report is back
          do @(posedge clk); while (pending_items.size() > 3);
          sender_hold = 1'b1;
          do @(posedge clk); while (line_reports.size() != 0);
          repeat (3) @(negedge clk);
          sender_hold = 1'b0;
        end
        if ($urandom_range(99) < 10) begin
          case ($urandom_range(2))
            0: begin
              repeat ($urandom_range(3)) push_item(ACT_DATA, pick_text_byte(), PIDX_W'($urandom));
              push_item(ACT_START, 8'($urandom), PIDX_W'($urandom));
            end
            1: push_item(ACT_UNUSED, 8'($urandom), PIDX_W'($urandom));
            default: push_item(ACT_PATW, pick_text_byte(), PIDX_W'($urandom_range(127)));
          endcase
        end
        line_len = (len > 40) ? $urandom_range(len + 20, len - 5) : $urandom_range(len + 10, 0);
        sel = $urandom_range(2);
        where = (sel != 0 && len > 0 && line_len >= len) ? $urandom_range(line_len - len) : -1;
        push_line(line_len, where, sel == 2);
      end
      phase++;
    end

    drain();
    $display("Covered %0d transfers and %0d line reports (%0d matching), %0d length settings",
             n_transfers, n_reports, n_matched, n_lengths);
    $display("Longest kept line %0d bytes; lengths 0, 1 and %0d among the settings",
             max_kept, LSM_PATTERN_MAX);
    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin : watchdog
    #4_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

>>> line_substring_matcher_top.f
hdl/lsm_pkg.sv
hdl/lsm_matcher.sv
hdl/line_substring_matcher_top.sv
tb/line_substring_matcher_top_tb.sv
